[sv/bgc_pkg.sv]
`timescale 1ns / 1ps

package bgc_pkg;

  localparam int DefMaxNodes = 32;
  localparam int RowLimit    = 32;
  localparam int RowW        = 32;
  localparam int RowIdxW     = 5;
  localparam int CfgW        = 6;
  localparam int ColW        = 5;
  localparam int CandW       = 6;

  localparam logic [CfgW-1:0]  NodeCountRst  = 6'd32;
  localparam logic [CfgW-1:0]  ColorLimitRst = 6'd4;
  localparam logic [CandW-1:0] ColorCap      = 6'd32;

  typedef enum logic {
    CfgNodeCount  = 1'b0,
    CfgColorLimit = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdStart = 1'b1
  } cmd_e;

  typedef struct packed {
    logic load;
    logic init;
    logic take;
    logic next;
    logic back;
    logic emit;
    logic fail;
    logic empty;
  } dp_cmd_t;

  typedef struct packed {
    logic node_done;
    logic cand_out;
    logic at_root;
    logic conflict;
    logic is_last;
  } dp_status_t;

endpackage

[sv/bgc_ctrl.sv]
`timescale 1ns / 1ps

module bgc_ctrl
  import bgc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       cmd_i,
  input  logic       out_stall_i,
  input  dp_status_t st_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StEmit,
    StFail,
    StEmpty
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q & out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (cmd_i == CmdStart) begin
            cmd_o.init = 1'b1;
            state_d    = StSearch;
          end else begin
            cmd_o.load = 1'b1;
          end
        end
      end
      StSearch: begin
        if (st_i.node_done) begin
          if (st_i.at_root) begin
            state_d = StEmpty;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = StEmit;
          end
        end else if (st_i.cand_out) begin
          if (st_i.at_root) begin
            state_d = StFail;
          end else begin
            cmd_o.back = 1'b1;
          end
        end else if (st_i.conflict) begin
          cmd_o.next = 1'b1;
        end else begin
          cmd_o.take = 1'b1;
        end
      end
      StEmit: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          if (st_i.is_last) begin
            state_d = StIdle;
          end
        end
      end
      StFail: begin
        if (out_free) begin
          cmd_o.fail  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      StEmpty: begin
        if (out_free) begin
          cmd_o.empty = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[sv/bgc_datapath.sv]
`timescale 1ns / 1ps

module bgc_datapath
  import bgc_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic [RowIdxW-1:0] row_index_i,
  input  logic [RowW-1:0]    row_bits_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         st_o,
  output logic [RowIdxW-1:0] node_index_o,
  output logic [ColW-1:0]    node_color_o,
  output logic               colorable_o,
  output logic               last_o
);

  localparam int RowCnt = (MAX_NODES < RowLimit) ? MAX_NODES : RowLimit;
  localparam int NodeW  = $clog2(RowCnt + 1);
  localparam int IdxW   = $clog2(RowCnt);

  logic [CfgW-1:0]   node_count_q;
  logic [CfgW-1:0]   color_limit_q;
  logic [RowCnt-1:0] adj_q [RowCnt];
  logic [ColW-1:0]   col_q [RowCnt];
  logic [NodeW-1:0]  node_q;
  logic [CandW-1:0]  cand_q;

  logic [RowIdxW-1:0] out_idx_q;
  logic [ColW-1:0]    out_col_q;
  logic               out_ok_q;
  logic               out_last_q;

  logic [NodeW-1:0]  eff_n;
  logic [CandW-1:0]  lim;
  logic [IdxW-1:0]   node_idx;
  logic [NodeW-1:0]  rd_node;
  logic [ColW-1:0]   rd_col;
  logic [RowCnt-1:0] hit;

  assign eff_n    = (node_count_q > CfgW'(RowCnt)) ? NodeW'(RowCnt) : NodeW'(node_count_q);
  assign lim      = (color_limit_q > ColorCap) ? ColorCap : color_limit_q;
  assign node_idx = node_q[IdxW-1:0];
  assign rd_node  = cmd_i.back ? (node_q - 1'b1) : node_q;
  assign rd_col   = col_q[rd_node[IdxW-1:0]];

  always_comb begin
    for (int i = 0; i < RowCnt; i++) begin
      hit[i] = (NodeW'(i) < node_q) && adj_q[i][node_idx]
               && ({1'b0, col_q[i]} == cand_q);
    end
  end

  assign st_o.node_done = (node_q >= eff_n);
  assign st_o.cand_out  = (cand_q >= lim);
  assign st_o.at_root   = (node_q == '0);
  assign st_o.conflict  = |hit;
  assign st_o.is_last   = (({1'b0, node_q} + 1'b1) == {1'b0, eff_n});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q  <= NodeCountRst;
      color_limit_q <= ColorLimitRst;
      node_q        <= '0;
      cand_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgNodeCount:  node_count_q  <= cfg_data_i;
          CfgColorLimit: color_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.init) begin
        node_q <= '0;
        cand_q <= '0;
      end else if (cmd_i.take) begin
        node_q <= node_q + 1'b1;
        cand_q <= '0;
      end else if (cmd_i.next) begin
        cand_q <= cand_q + 1'b1;
      end else if (cmd_i.back) begin
        node_q <= node_q - 1'b1;
        cand_q <= {1'b0, rd_col} + CandW'(1);
      end else if (cmd_i.emit) begin
        node_q <= node_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ({1'b0, row_index_i} < (RowIdxW + 1)'(RowCnt))) begin
      adj_q[row_index_i[IdxW-1:0]] <= row_bits_i[RowCnt-1:0];
    end
    if (cmd_i.take) begin
      col_q[node_idx] <= cand_q[ColW-1:0];
    end
    if (cmd_i.emit) begin
      out_idx_q  <= RowIdxW'(node_idx);
      out_col_q  <= rd_col;
      out_ok_q   <= 1'b1;
      out_last_q <= st_o.is_last;
    end else if (cmd_i.fail || cmd_i.empty) begin
      out_idx_q  <= '0;
      out_col_q  <= '0;
      out_ok_q   <= cmd_i.empty;
      out_last_q <= 1'b1;
    end
  end

  assign node_index_o = out_idx_q;
  assign node_color_o = out_col_q;
  assign colorable_o  = out_ok_q;
  assign last_o       = out_last_q;

endmodule

[sv/backtracking_graph_coloring.sv]
// Row load: the block stays idle, so the next transaction may follow at once.
// Start: one search step at a time (a colour tested, a node coloured or a backtrack), the
//   test against earlier nodes setting the step; then the results one by one as the output
//   is free; failure is reported after the last backtrack, an empty graph via StEmpty.
// A new transaction is taken only in idle; the last result may still wait in the output.
// Reset (async, active low): idle, node_count 32, color_limit 4; adjacency rows undefined.
`timescale 1ns / 1ps

module backtracking_graph_coloring
  import bgc_pkg::*;
#(
  parameter int MAX_NODES = DefMaxNodes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [RowIdxW-1:0] row_index_i,
  input  logic [RowW-1:0]    row_bits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [RowIdxW-1:0] node_index_o,
  output logic [ColW-1:0]    node_color_o,
  output logic               colorable_o,
  output logic               last_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;

  bgc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .out_stall_i (out_stall_i),
    .st_i        (dp_st),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (dp_cmd)
  );

  bgc_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .row_index_i  (row_index_i),
    .row_bits_i   (row_bits_i),
    .cmd_i        (dp_cmd),
    .st_o         (dp_st),
    .node_index_o (node_index_o),
    .node_color_o (node_color_o),
    .colorable_o  (colorable_o),
    .last_o       (last_o)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == CmdStart) |=> in_stall_o)
    else $error("start transaction did not make the block busy");

  a_fail_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !colorable_o |-> (node_index_o == '0) && (node_color_o == '0) && last_o)
    else $error("not-colourable result malformed");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(dp_cmd))
    else $error("more than one datapath command at once");

endmodule

[bench/backtracking_graph_coloring_tb.sv]
`timescale 1ns / 1ps

module backtracking_graph_coloring_tb;
  import bgc_pkg::*;

  localparam int ItemTarget    = 410;
  localparam int StepBudget    = 1500;
  localparam int WatchdogLimit = 200000;
  localparam int SettleCycles  = 12;
  localparam int LongHold      = 400;
  localparam logic [CandW-1:0] Uncoloured = 6'd63;

  typedef enum int {
    GraphRandom,
    GraphSparse,
    GraphClique,
    GraphDense,
    GraphEmpty
  } graph_kind_e;

  typedef struct {
    cmd_e               cmd;
    logic [RowIdxW-1:0] row;
    logic [RowW-1:0]    bits;
  } txn_t;

  typedef struct {
    logic [RowIdxW-1:0] node;
    logic [ColW-1:0]    colour;
    logic               ok;
    logic               fin;
  } colouring_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic               cmd_i = 1'b0;
  logic [RowIdxW-1:0] row_index_i = '0;
  logic [RowW-1:0]    row_bits_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [RowIdxW-1:0] node_index_o;
  logic [ColW-1:0]    node_color_o;
  logic               colorable_o;
  logic               last_o;

  txn_t            pending [$];
  colouring_t      colours_due [$];
  txn_t            offered;
  logic [RowW-1:0] row_model [RowLimit];
  logic [RowW-1:0] plan_adj [RowLimit];
  logic [CfgW-1:0] cfg_nodes = NodeCountRst;
  logic [CfgW-1:0] cfg_colours = ColorLimitRst;

  bit in_acc;
  bit quiet;
  bit failed;
  int gap_left;
  int stall_left;
  int hold_left;
  int holds_done;
  int results_seen;
  int quiet_cycles;
  int total_items;

  backtracking_graph_coloring u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .row_index_i (row_index_i),
    .row_bits_i  (row_bits_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .node_index_o(node_index_o),
    .node_color_o(node_color_o),
    .colorable_o (colorable_o),
    .last_o      (last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clip32(input int v);
    return (v > RowLimit) ? RowLimit : v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Depth-first m-colouring in node order; steps counts colour tests and backtracks.
  function automatic bit colour_search(input logic [RowW-1:0] adj [RowLimit], input int n,
                                       input int lim, output logic [CandW-1:0] col [RowLimit],
                                       output int steps);
    int node;
    int start;
    int c;
    bit clash;
    node = 0;
    start = 0;
    steps = 0;
    for (int i = 0; i < RowLimit; i++) col[i] = Uncoloured;
    while (1) begin
      if (node >= n) return 1'b1;
      for (c = start; c < lim; c++) begin
        steps++;
        clash = 1'b0;
        for (int i = 0; i < node; i++)
          if (adj[i][node] && col[i] == c) clash = 1'b1;
        if (!clash) break;
      end
      if (c < lim) begin
        col[node] = CandW'(c);
        node++;
        start = 0;
      end else begin
        steps++;
        col[node] = Uncoloured;
        if (node == 0) return 1'b0;
        node--;
        start = int'(col[node]) + 1;
        col[node] = Uncoloured;
      end
    end
  endfunction

  function automatic void predict_colouring(input txn_t t);
    logic [CandW-1:0] col [RowLimit];
    colouring_t r;
    int n;
    int lim;
    int steps;
    if (t.cmd == CmdLoad) begin
      row_model[t.row] = t.bits;
      return;
    end
    n = clip32(int'(cfg_nodes));
    lim = clip32(int'(cfg_colours));
    r.node = '0;
    r.colour = '0;
    r.fin = 1'b1;
    if (n == 0) begin
      r.ok = 1'b1;
      colours_due.push_back(r);
    end else if (!colour_search(row_model, n, lim, col, steps)) begin
      r.ok = 1'b0;
      colours_due.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.node = RowIdxW'(k);
        r.colour = col[k][ColW-1:0];
        r.ok = 1'b1;
        r.fin = (k == n - 1);
        colours_due.push_back(r);
      end
    end
  endfunction

  function automatic logic [RowW-1:0] row_pattern(input graph_kind_e kind, input int i,
                                                  input int clique);
    case (kind)
      GraphRandom: return $urandom;
      GraphSparse: return $urandom & $urandom & $urandom;
      GraphClique: return (i < clique) ? 32'((64'd1 << clique) - 1) : ($urandom & $urandom);
      GraphDense:  return $urandom | $urandom;
      default:     return '0;
    endcase
  endfunction

  task automatic push_load(input int row, input logic [RowW-1:0] bits);
    txn_t t;
    t.cmd = CmdLoad;
    t.row = RowIdxW'(row);
    t.bits = bits;
    pending.push_back(t);
    plan_adj[row] = bits;
    total_items++;
  endtask

  task automatic push_start();
    txn_t t;
    t.cmd = CmdStart;
    t.row = RowIdxW'($urandom);
    t.bits = $urandom;
    pending.push_back(t);
    total_items++;
  endtask

  task automatic queue_graph(input int n, input int lim);
    logic [RowW-1:0]  trial [RowLimit];
    logic [CandW-1:0] col [RowLimit];
    graph_kind_e kind;
    int steps;
    int clique;
    if (n == 0) begin
      push_start();
      return;
    end
    for (int t = 0; t < 40; t++) begin
      trial = plan_adj;
      kind = graph_kind_e'($urandom_range(0, 4));
      clique = $urandom_range(1, n);
      for (int i = 0; i < n; i++) trial[i] = row_pattern(kind, i, clique);
      void'(colour_search(trial, n, lim, col, steps));
      if (steps <= StepBudget) break;
      if (t == 39)
        for (int i = 0; i < n; i++) trial[i] = '0;
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) push_load(i, $urandom);
      push_load(i, trial[i]);
    end
    if (n < RowLimit)
      repeat ($urandom_range(0, 2)) push_load($urandom_range(n, RowLimit - 1), $urandom);
    push_start();
    if ($urandom_range(0, 4) == 0) push_start();
  endtask

  task automatic settle();
    while (pending.size() != 0 || in_valid_i || colours_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(input int nodes, input int colours);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CfgNodeCount;
    cfg_data_i <= CfgW'(nodes);
    cfg_nodes = CfgW'(nodes);
    @(negedge clk_i);
    cfg_index_i <= CfgColorLimit;
    cfg_data_i <= CfgW'(colours);
    cfg_colours = CfgW'(colours);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_reg(input int lo, input int hi);
    if ($urandom_range(0, 7) != 0) return $urandom_range(lo, hi);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 32;
      2:       return 63;
      default: return $urandom_range(33, 62);
    endcase
  endfunction

  initial begin
    int nc;
    int cl;
    for (int i = 0; i < RowLimit; i++) begin
      row_model[i] = '0;
      plan_adj[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_config(0, 1);
    push_start();
    settle();
    set_config(1, 0);
    push_start();
    settle();
    set_config(2, 1);
    push_load(0, 32'h0000_0001);
    push_load(31, 32'hFFFF_FFFF);
    push_load(1, 32'h0000_0000);
    push_start();
    push_load(0, 32'hFFFF_FFFF);
    push_start();
    settle();
    set_config(3, 2);
    push_load(1, 32'h0000_0000);
    push_start();
    push_load(31, 32'h0000_0000);
    settle();
    set_config(63, 63);
    for (int i = 0; i < RowLimit; i++) push_load(i, 32'hFFFF_FFFF);
    push_start();
    queue_graph(RowLimit, RowLimit);
    settle();
    set_config(32, 4);
    queue_graph(RowLimit, 4);
    settle();
    set_config(32, 1);
    queue_graph(RowLimit, 1);

    while (total_items < ItemTarget) begin
      nc = pick_reg(1, 12);
      cl = pick_reg(1, 5);
      settle();
      set_config(nc, cl);
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) queue_graph(clip32(nc), clip32(cl));
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (colours_due.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    in_acc = rst_ni && in_valid_i && !in_stall_o;
    if (in_acc) predict_colouring(offered);
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_acc) begin
      if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (pending.size() != 0) begin
        offered = pending.pop_front();
        cmd_i <= offered.cmd;
        row_index_i <= offered.row;
        row_bits_i <= offered.bits;
        in_valid_i <= 1'b1;
        gap_left = quiet ? 0 : pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Hold the output off for a long stretch up to twice while transactions are still queued, else stall it at random.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (holds_done < 2 && out_valid_o && pending.size() > 4 &&
                 results_seen >= (holds_done == 0 ? 30 : 250)) begin
      out_stall_i <= 1'b1;
      hold_left = LongHold;
      holds_done++;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      stall_left = quiet ? 0 : pick_gap();
    end
  end

  always @(posedge clk_i) begin
    colouring_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (colours_due.size() == 0) begin
        $error("unexpected result: node_index %0d node_color %0d colorable %0d last %0d",
               node_index_o, node_color_o, colorable_o, last_o);
        failed = 1'b1;
      end else begin
        e = colours_due.pop_front();
        if (node_index_o !== e.node) begin
          $error("node_index: expected %0d, got %0d", e.node, node_index_o);
          failed = 1'b1;
        end
        if (node_color_o !== e.colour) begin
          $error("node_color: expected %0d, got %0d", e.colour, node_color_o);
          failed = 1'b1;
        end
        if (colorable_o !== e.ok) begin
          $error("colorable: expected %0d, got %0d", e.ok, colorable_o);
          failed = 1'b1;
        end
        if (last_o !== e.fin) begin
          $error("last: expected %0d, got %0d", e.fin, last_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
